// ===== design/htrp_pkg.sv =====
// shared types, codes and reset values for the hex tlv record parser
`timescale 1ns / 1ps

package htrp_pkg;

   localparam int QUEUE_DEPTH = 2;

   // record kinds on the result channel
   localparam logic [2:0] KIND_ADDR      = 3'd4;
   localparam logic [2:0] KIND_STAMP_OVF = 3'd5;
   localparam logic [2:0] KIND_STAMP     = 3'd6;
   localparam logic [2:0] KIND_END       = 3'd7;
   localparam logic [2:0] KIND_UNKNOWN   = 3'd7;
   localparam logic [2:0] KIND_LAST_PAYLOAD = 3'd3;

   // line end status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_PAIR    = 2'd1;
   localparam logic [1:0] STATUS_HEX_SEP = 2'd2;
   localparam logic [1:0] STATUS_BAD_TAG = 2'd3;

   // csr register indexes
   localparam logic [2:0] CSR_TAG_TS      = 3'd0;
   localparam logic [2:0] CSR_TAG_RS      = 3'd1;
   localparam logic [2:0] CSR_TAG_DATA    = 3'd2;
   localparam logic [2:0] CSR_TAG_SOURCE  = 3'd3;
   localparam logic [2:0] CSR_TAG_ADDRESS = 3'd4;
   localparam logic [2:0] CSR_TAG_STAMP   = 3'd5;

   // tag reset codes
   localparam logic [7:0] RST_TAG_TS      = 8'd0;
   localparam logic [7:0] RST_TAG_RS      = 8'd1;
   localparam logic [7:0] RST_TAG_DATA    = 8'd2;
   localparam logic [7:0] RST_TAG_SOURCE  = 8'd3;
   localparam logic [7:0] RST_TAG_ADDRESS = 8'd4;
   localparam logic [7:0] RST_TAG_STAMP   = 8'd5;

   typedef struct packed {
      logic [7:0] ts;
      logic [7:0] rs;
      logic [7:0] data;
      logic [7:0] source;
      logic [7:0] address;
      logic [7:0] stamp;
   } htrp_tags_type;

   // byte or line end event from the character front end
   typedef struct packed {
      logic       is_end;
      logic [1:0] status;
      logic [7:0] data;
   } htrp_evt_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] value;
      logic [7:0]  position;
      logic        last;
      logic        empty;
      logic [1:0]  status;
   } htrp_rsp_type;

   typedef enum logic [2:0] {
      STEP_TAG,
      STEP_LEN,
      STEP_PAYLOAD,
      STEP_GATHER,
      STEP_OVF_LEN,
      STEP_STAMP_LEN
   } htrp_step_type;

endpackage

// ===== design/hex_tlv_record_parser_unit.sv =====
// top level of the hex tlv record parser: tag registers, front end, queue, back end
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_text_char
//   rsp     | out       | rsp_valid / rsp_stall | kind, value, position, last, empty, status
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// one character is taken per cycle while req_stall is low; the back end retires one
// queued byte or line end per cycle unless rsp_stall holds it, so the sustained rate is
// one character a cycle; a result passes from the queue entry of the character that
// completes it to the result register; the queue holds two events
// rsp_stall holds the result register, the queue then fills and req_stall rises
// reset is synchronous and returns all line state and tag codes to defaults
`timescale 1ns / 1ps

module hex_tlv_record_parser_unit
   import htrp_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_record_kind,
   output logic [63:0] rsp_value,
   output logic [7:0]  rsp_position,
   output logic        rsp_record_last,
   output logic        rsp_empty_res,
   output logic [1:0]  rsp_line_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   htrp_tags_type tags_ff, tags_in;
   logic          req_accept;
   logic          evt_push;
   htrp_evt_type  push_evt;
   logic          q_full;
   logic          q_valid;
   htrp_evt_type  q_head;
   logic          q_pop;
   htrp_rsp_type  rsp;

   assign csr_ready  = 1'b1;
   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   always_comb begin
      tags_in = tags_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TAG_TS:      tags_in.ts      = csr_data;
            CSR_TAG_RS:      tags_in.rs      = csr_data;
            CSR_TAG_DATA:    tags_in.data    = csr_data;
            CSR_TAG_SOURCE:  tags_in.source  = csr_data;
            CSR_TAG_ADDRESS: tags_in.address = csr_data;
            CSR_TAG_STAMP:   tags_in.stamp   = csr_data;
            default: begin
               tags_in = tags_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tags_ff.ts      <= RST_TAG_TS;
         tags_ff.rs      <= RST_TAG_RS;
         tags_ff.data    <= RST_TAG_DATA;
         tags_ff.source  <= RST_TAG_SOURCE;
         tags_ff.address <= RST_TAG_ADDRESS;
         tags_ff.stamp   <= RST_TAG_STAMP;
      end else begin
         tags_ff <= tags_in;
      end
   end

   htrp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .char_accept (req_accept),
      .text_char   (req_text_char),
      .evt_push    (evt_push),
      .evt         (push_evt)
   );

   htrp_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (evt_push),
      .push_data  (push_evt),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   htrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tags      (tags_ff),
      .evt_valid (q_valid),
      .evt       (q_head),
      .evt_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_record_kind = rsp.kind;
   assign rsp_value       = rsp.value;
   assign rsp_position    = rsp.position;
   assign rsp_record_last = rsp.last;
   assign rsp_empty_res   = rsp.empty;
   assign rsp_line_status = rsp.status;

endmodule

// ===== design/htrp_front.sv =====
// character front end: pairs hex characters into bytes and spots line ends
`timescale 1ns / 1ps

module htrp_front
   import htrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         char_accept,
   input  logic [7:0]   text_char,
   output logic         evt_push,
   output htrp_evt_type evt
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] high_ff, high_in;
   logic [7:0] pend_ff, pend_in;
   logic       skip_ff, skip_in;

   logic       is_term;
   logic       is_hex;
   logic [3:0] nib;

   always_comb begin
      is_hex = 1'b1;
      nib    = 4'd0;
      if (text_char >= 8'h30 && text_char <= 8'h39) begin
         nib = text_char[3:0];
      end else if ((text_char >= 8'h41 && text_char <= 8'h46) ||
                   (text_char >= 8'h61 && text_char <= 8'h66)) begin
         nib = text_char[3:0] + 4'd9;
      end else begin
         is_hex = 1'b0;
      end
   end

   assign is_term = (text_char == 8'h00) || (text_char == 8'h0A) || (text_char == 8'h0D);

   always_comb begin
      phase_in = phase_ff;
      high_in  = high_ff;
      pend_in  = pend_ff;
      skip_in  = skip_ff;
      evt_push = 1'b0;
      evt      = '0;
      if (char_accept) begin
         if (is_term) begin
            evt_push   = 1'b1;
            evt.is_end = 1'b1;
            if (skip_ff) begin
               evt.status = STATUS_HEX_SEP;
            end else if (phase_ff == 2'd1) begin
               evt.status = STATUS_PAIR;
            end else begin
               evt.status = STATUS_OK;
            end
            phase_in = 2'd0;
            high_in  = 4'd0;
            pend_in  = 8'd0;
            skip_in  = 1'b0;
         end else if (!skip_ff) begin
            unique case (phase_ff)
               2'd0: begin
                  high_in  = nib;
                  phase_in = 2'd1;
               end
               2'd1: begin
                  pend_in  = {high_ff, nib};
                  phase_in = 2'd2;
               end
               default: begin
                  if (is_hex) begin
                     skip_in = 1'b1;
                  end else begin
                     phase_in = 2'd0;
                     evt_push = 1'b1;
                     evt.data = pend_ff;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         high_ff  <= 4'd0;
         pend_ff  <= 8'd0;
         skip_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         high_ff  <= high_in;
         pend_ff  <= pend_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

// ===== design/htrp_queue.sv =====
// short event queue between the character front end and the record back end
`timescale 1ns / 1ps

module htrp_queue
   import htrp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  htrp_evt_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output htrp_evt_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   htrp_evt_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/htrp_back.sv =====
// record back end: walks tag, length and payload bytes and drives the result register
`timescale 1ns / 1ps

module htrp_back
   import htrp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  htrp_tags_type tags,
   input  logic          evt_valid,
   input  htrp_evt_type  evt,
   output logic          evt_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output htrp_rsp_type  rsp
);

   htrp_step_type step_ff, step_in;
   logic [2:0]    kind_ff, kind_in;
   logic [7:0]    left_ff, left_in;
   logic [7:0]    idx_ff, idx_in;
   logic [63:0]   acc_ff, acc_in;
   logic          skip_ff, skip_in;

   logic          rsp_valid_ff, rsp_valid_in;
   htrp_rsp_type  rsp_ff;

   logic          fire;
   logic          emit;
   htrp_rsp_type  res;
   logic [7:0]    b;
   logic [63:0]   acc_next;
   logic [2:0]    tag_kind;

   assign fire     = evt_valid && (!rsp_valid_ff || !rsp_stall);
   assign evt_pop  = fire;
   assign b        = evt.data;
   assign acc_next = {acc_ff[55:0], b};

   always_comb begin
      priority if (b == tags.ts)      tag_kind = 3'd0;
      else if (b == tags.rs)          tag_kind = 3'd1;
      else if (b == tags.data)        tag_kind = 3'd2;
      else if (b == tags.source)      tag_kind = 3'd3;
      else if (b == tags.address)     tag_kind = KIND_ADDR;
      else if (b == tags.stamp)       tag_kind = KIND_STAMP_OVF;
      else                            tag_kind = KIND_UNKNOWN;
   end

   always_comb begin
      step_in = step_ff;
      kind_in = kind_ff;
      left_in = left_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      skip_in = skip_ff;
      emit    = 1'b0;
      res     = '0;
      if (fire) begin
         if (evt.is_end) begin
            emit       = 1'b1;
            res.kind   = KIND_END;
            res.status = skip_ff ? STATUS_BAD_TAG : evt.status;
            step_in    = STEP_TAG;
            kind_in    = 3'd0;
            left_in    = 8'd0;
            idx_in     = 8'd0;
            acc_in     = 64'd0;
            skip_in    = 1'b0;
         end else if (!skip_ff) begin
            unique case (step_ff)
               STEP_TAG: begin
                  kind_in = tag_kind;
                  step_in = STEP_LEN;
               end
               STEP_LEN: begin
                  if (kind_ff == KIND_UNKNOWN) begin
                     skip_in = 1'b1;
                  end else if (kind_ff <= KIND_LAST_PAYLOAD) begin
                     left_in = b;
                     idx_in  = 8'd0;
                     if (b == 8'd0) begin
                        emit      = 1'b1;
                        res.kind  = kind_ff;
                        res.empty = 1'b1;
                        step_in   = STEP_TAG;
                     end else begin
                        step_in = STEP_PAYLOAD;
                     end
                  end else if (kind_ff == KIND_ADDR) begin
                     acc_in  = 64'd0;
                     left_in = b;
                     if (b == 8'd0) begin
                        emit     = 1'b1;
                        res.kind = kind_ff;
                        res.last = 1'b1;
                        step_in  = STEP_TAG;
                     end else begin
                        step_in = STEP_GATHER;
                     end
                  end else begin
                     // outer stamp length is ignored
                     step_in = STEP_OVF_LEN;
                  end
               end
               STEP_PAYLOAD: begin
                  emit         = 1'b1;
                  res.kind     = kind_ff;
                  res.value    = {56'd0, b};
                  res.position = idx_ff;
                  res.last     = (left_ff == 8'd1);
                  idx_in       = idx_ff + 8'd1;
                  left_in      = left_ff - 8'd1;
                  if (left_ff == 8'd1) begin
                     step_in = STEP_TAG;
                  end
               end
               STEP_GATHER: begin
                  acc_in  = acc_next;
                  left_in = left_ff - 8'd1;
                  if (left_ff == 8'd1) begin
                     emit      = 1'b1;
                     res.kind  = kind_ff;
                     res.value = acc_next;
                     res.last  = 1'b1;
                     step_in   = (kind_ff == KIND_STAMP_OVF) ? STEP_STAMP_LEN : STEP_TAG;
                  end
               end
               STEP_OVF_LEN: begin
                  kind_in = KIND_STAMP_OVF;
                  acc_in  = 64'd0;
                  left_in = b;
                  if (b == 8'd0) begin
                     emit     = 1'b1;
                     res.kind = KIND_STAMP_OVF;
                     res.last = 1'b1;
                     step_in  = STEP_STAMP_LEN;
                  end else begin
                     step_in = STEP_GATHER;
                  end
               end
               STEP_STAMP_LEN: begin
                  kind_in = KIND_STAMP;
                  acc_in  = 64'd0;
                  left_in = b;
                  if (b == 8'd0) begin
                     emit     = 1'b1;
                     res.kind = KIND_STAMP;
                     res.last = 1'b1;
                     step_in  = STEP_TAG;
                  end else begin
                     step_in = STEP_GATHER;
                  end
               end
               default: begin
                  step_in = STEP_TAG;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_TAG;
         kind_ff      <= 3'd0;
         left_ff      <= 8'd0;
         idx_ff       <= 8'd0;
         acc_ff       <= 64'd0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         kind_ff      <= kind_in;
         left_ff      <= left_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== test/tb_top.sv =====
// testbench for the hex tlv record parser: predicts every record and line end and checks them
`timescale 1ns / 1ps

module tb_top
   import htrp_pkg::*;
();

   localparam logic [2:0] KIND_TS     = 3'd0;
   localparam logic [2:0] KIND_RS     = 3'd1;
   localparam logic [2:0] KIND_DATA   = 3'd2;
   localparam logic [2:0] KIND_SOURCE = 3'd3;

   localparam logic [7:0] CHR_NUL      = 8'h00;
   localparam logic [7:0] CHR_LINEFEED = 8'h0A;
   localparam logic [7:0] CHR_RETURN   = 8'h0D;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;

   typedef enum logic [1:0] {PH_HIGH, PH_LOW, PH_SEP} text_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_char = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_record_kind;
   logic [63:0] rsp_value;
   logic [7:0]  rsp_position;
   logic        rsp_record_last;
   logic        rsp_empty_res;
   logic [1:0]  rsp_line_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [7:0]  csr_data = 8'h00;

   // tag codes as the block holds them, indexed by register index
   logic [7:0] tag_code [6] = '{RST_TAG_TS, RST_TAG_RS, RST_TAG_DATA,
                                RST_TAG_SOURCE, RST_TAG_ADDRESS, RST_TAG_STAMP};

   // line parser state
   text_phase_type txt_phase;
   logic [3:0]     hi_nib;
   logic [7:0]     pend_byte;
   htrp_step_type  rec_step;
   logic [2:0]     rec_kind;
   logic [7:0]     rec_left;
   logic [7:0]     rec_index;
   logic [63:0]    gather_acc;
   logic           line_dead;
   logic [1:0]     line_err;

   htrp_rsp_type expected_records [$];

   int  mismatches = 0;
   int  chars_sent = 0;
   int  cycle_count = 0;
   int  hold_rsp_cycles = 0;
   int  stall_run = 0;
   bit  burst_mode = 1'b0;

   hex_tlv_record_parser_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_char   (req_text_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_record_kind (rsp_record_kind),
      .rsp_value       (rsp_value),
      .rsp_position    (rsp_position),
      .rsp_record_last (rsp_record_last),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_line_status (rsp_line_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit chance(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic bit is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   function automatic bit is_line_end(input logic [7:0] c);
      return c == CHR_NUL || c == CHR_LINEFEED || c == CHR_RETURN;
   endfunction

   function automatic logic [3:0] nibble_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      return 4'd0;
   endfunction

   function automatic logic [2:0] tag_kind(input logic [7:0] t);
      if (t == tag_code[CSR_TAG_TS]) return KIND_TS;
      if (t == tag_code[CSR_TAG_RS]) return KIND_RS;
      if (t == tag_code[CSR_TAG_DATA]) return KIND_DATA;
      if (t == tag_code[CSR_TAG_SOURCE]) return KIND_SOURCE;
      if (t == tag_code[CSR_TAG_ADDRESS]) return KIND_ADDR;
      if (t == tag_code[CSR_TAG_STAMP]) return KIND_STAMP_OVF;
      return KIND_UNKNOWN;
   endfunction

   task automatic clear_line();
      txt_phase  = PH_HIGH;
      hi_nib     = '0;
      pend_byte  = '0;
      rec_step   = STEP_TAG;
      rec_kind   = '0;
      rec_left   = '0;
      rec_index  = '0;
      gather_acc = '0;
      line_dead  = 1'b0;
      line_err   = STATUS_OK;
   endtask

   task automatic expect_record(input logic [2:0] kind, input logic [63:0] value,
                                input logic [7:0] pos, input logic last,
                                input logic empty, input logic [1:0] status);
      htrp_rsp_type r;
      r.kind     = kind;
      r.value    = value;
      r.position = pos;
      r.last     = last;
      r.empty    = empty;
      r.status   = status;
      expected_records.push_back(r);
   endtask

   task automatic start_gather(input logic [7:0] len, input htrp_step_type after);
      gather_acc = '0;
      rec_left   = len;
      if (len == 8'd0) begin
         expect_record(rec_kind, '0, '0, 1'b1, 1'b0, STATUS_OK);
         rec_step = (rec_kind == KIND_STAMP_OVF) ? STEP_STAMP_LEN : after;
      end else begin
         rec_step = STEP_GATHER;
      end
   endtask

   task automatic take_byte(input logic [7:0] b);
      case (rec_step)
         STEP_TAG: begin
            rec_kind = tag_kind(b);
            rec_step = STEP_LEN;
         end
         STEP_LEN: begin
            if (rec_kind == KIND_UNKNOWN) begin
               line_err  = STATUS_BAD_TAG;
               line_dead = 1'b1;
            end else if (rec_kind <= KIND_LAST_PAYLOAD) begin
               rec_left  = b;
               rec_index = '0;
               if (b == 8'd0) begin
                  expect_record(rec_kind, '0, '0, 1'b0, 1'b1, STATUS_OK);
                  rec_step = STEP_TAG;
               end else begin
                  rec_step = STEP_PAYLOAD;
               end
            end else if (rec_kind == KIND_ADDR) begin
               start_gather(b, STEP_TAG);
            end else begin
               // outer stamp length carries no meaning
               rec_step = STEP_OVF_LEN;
            end
         end
         STEP_PAYLOAD: begin
            expect_record(rec_kind, 64'(b), rec_index, rec_left == 8'd1, 1'b0, STATUS_OK);
            rec_index = rec_index + 8'd1;
            rec_left  = rec_left - 8'd1;
            if (rec_left == 8'd0) rec_step = STEP_TAG;
         end
         STEP_GATHER: begin
            gather_acc = {gather_acc[55:0], b};
            rec_left   = rec_left - 8'd1;
            if (rec_left == 8'd0) begin
               expect_record(rec_kind, gather_acc, '0, 1'b1, 1'b0, STATUS_OK);
               rec_step = (rec_kind == KIND_STAMP_OVF) ? STEP_STAMP_LEN : STEP_TAG;
            end
         end
         STEP_OVF_LEN: begin
            rec_kind = KIND_STAMP_OVF;
            start_gather(b, STEP_STAMP_LEN);
         end
         STEP_STAMP_LEN: begin
            rec_kind = KIND_STAMP;
            start_gather(b, STEP_TAG);
         end
         default: rec_step = STEP_TAG;
      endcase
   endtask

   task automatic parse_char(input logic [7:0] c);
      logic [1:0] status;
      if (is_line_end(c)) begin
         if (line_dead) status = line_err;
         else if (txt_phase == PH_LOW) status = STATUS_PAIR;
         else status = STATUS_OK;
         expect_record(KIND_END, '0, '0, 1'b0, 1'b0, status);
         clear_line();
      end else if (!line_dead) begin
         case (txt_phase)
            PH_HIGH: begin
               hi_nib    = nibble_value(c);
               txt_phase = PH_LOW;
            end
            PH_LOW: begin
               pend_byte = {hi_nib, nibble_value(c)};
               txt_phase = PH_SEP;
            end
            default: begin
               if (is_hex(c)) begin
                  line_err  = STATUS_HEX_SEP;
                  line_dead = 1'b1;
               end else begin
                  txt_phase = PH_HIGH;
                  take_byte(pend_byte);
               end
            end
         endcase
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : record_check
      htrp_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_records.size() == 0) begin
            report_mismatch("record with none pending, kind", 64'(rsp_record_kind), '0);
         end else begin
            want = expected_records.pop_front();
            if (rsp_record_kind !== want.kind)
               report_mismatch("record_kind", 64'(rsp_record_kind), 64'(want.kind));
            if (rsp_value !== want.value)
               report_mismatch("value", rsp_value, want.value);
            if (rsp_position !== want.position)
               report_mismatch("position", 64'(rsp_position), 64'(want.position));
            if (rsp_record_last !== want.last)
               report_mismatch("record_last", 64'(rsp_record_last), 64'(want.last));
            if (rsp_empty_res !== want.empty)
               report_mismatch("empty_res", 64'(rsp_empty_res), 64'(want.empty));
            if (rsp_line_status !== want.status)
               report_mismatch("line_status", 64'(rsp_line_status), 64'(want.status));
         end
      end
   end

   // receiver stalls; a requested hold-off wins over the random pattern
   always @(posedge clock) begin : rsp_stall_gen
      int r;
      if (hold_rsp_cycles > 0) begin
         hold_rsp_cycles--;
         rsp_stall <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         rsp_stall <= chance(35);
         r = $urandom_range(0, 99);
         if (r < 80) stall_run = $urandom_range(0, 3);
         else if (r < 95) stall_run = $urandom_range(4, 12);
         else stall_run = $urandom_range(20, 60);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int gap_length();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      if (n < 4'd10) return "0" + 8'(n);
      if (chance(50)) return "A" + 8'(n) - 8'd10;
      return "a" + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] separator_char();
      logic [7:0] c;
      if (chance(50)) return " ";
      do c = 8'($urandom_range(1, 255)); while (is_hex(c) || is_line_end(c));
      return c;
   endfunction

   function automatic logic [7:0] line_end_char();
      case ($urandom_range(0, 2))
         0: return CHR_NUL;
         1: return CHR_LINEFEED;
         default: return CHR_RETURN;
      endcase
   endfunction

   // valid stays high across back-to-back requests; it only drops for a gap or while records drain
   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_char <= c;
      do @(posedge clock); while (req_stall);
      parse_char(c);
      chars_sent++;
   endtask

   task automatic send_text(input string s, input logic [7:0] line_end);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
      send_char(line_end);
   endtask

   task automatic wait_records_done();
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_tags(input logic [7:0] ts, input logic [7:0] rs, input logic [7:0] data,
                           input logic [7:0] source, input logic [7:0] address,
                           input logic [7:0] stamp);
      logic [7:0] vals [6];
      logic [2:0] regs [6];
      vals = '{ts, rs, data, source, address, stamp};
      regs = '{CSR_TAG_TS, CSR_TAG_RS, CSR_TAG_DATA, CSR_TAG_SOURCE, CSR_TAG_ADDRESS,
               CSR_TAG_STAMP};
      csr_valid <= 1'b1;
      for (int i = 0; i < 6; i++) begin
         csr_index <= regs[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         tag_code[regs[i]] = vals[i];
      end
      csr_valid <= 1'b0;
   endtask

   // one line of tag-length records; broken lines carry bad digits, bad separators,
   // odd tags and endings inside a pair
   task automatic send_record_line(input bit broken);
      logic [7:0] line_bytes [$];
      logic [2:0] which;
      int nrec, len, cut;
      nrec = $urandom_range(1, 3);
      repeat (nrec) begin
         which = 3'($urandom_range(0, 5));
         line_bytes.push_back(tag_code[which]);
         if (which == CSR_TAG_ADDRESS) begin
            len = $urandom_range(0, 10);
         end else if (which == CSR_TAG_STAMP) begin
            line_bytes.push_back(8'($urandom_range(0, 255)));
            len = $urandom_range(0, 9);
            line_bytes.push_back(8'(len));
            repeat (len) line_bytes.push_back(8'($urandom_range(0, 255)));
            len = $urandom_range(0, 9);
         end else begin
            len = chance(10) ? 0 : $urandom_range(1, 6);
            if (chance(5)) len = $urandom_range(7, 24);
         end
         line_bytes.push_back(8'(len));
         repeat (len) line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (broken && chance(30)) line_bytes[0] = 8'($urandom_range(0, 255));
      if (chance(15)) begin
         cut = $urandom_range(0, line_bytes.size() - 1);
         while (line_bytes.size() > cut) void'(line_bytes.pop_back());
      end
      foreach (line_bytes[i]) begin
         send_char((broken && chance(4)) ? separator_char() : hex_digit(line_bytes[i][7:4]));
         send_char((broken && chance(4)) ? separator_char() : hex_digit(line_bytes[i][3:0]));
         send_char((broken && chance(4)) ? hex_digit(4'($urandom)) : separator_char());
      end
      if (broken) begin
         case ($urandom_range(0, 3))
            0: send_char(hex_digit(4'($urandom)));
            1: begin
               send_char(hex_digit(4'($urandom)));
               send_char(hex_digit(4'($urandom)));
            end
            default: ;
         endcase
      end
      send_char(line_end_char());
   endtask

   task automatic send_noise_line();
      repeat ($urandom_range(1, 20)) send_char(8'($urandom_range(0, 255)));
      send_char(line_end_char());
   endtask

   task automatic test_line_edges();
      send_text("A", CHR_LINEFEED);
      send_text("AB", CHR_NUL);
      send_text("ABC", CHR_RETURN);
      // all-ones characters: zero nibble and a plain separator
      send_char(8'hFF);
      send_char("B");
      send_char(8'hFF);
      send_char(CHR_LINEFEED);
      send_text("7f 00 ", CHR_LINEFEED);
      send_text("02 00 ", CHR_RETURN);
   endtask

   task automatic test_record_lines();
      while (chars_sent < 300) begin
         burst_mode = chance(20);
         send_record_line(1'b0);
      end
      burst_mode = 1'b0;
   endtask

   task automatic test_tag_settings();
      int target;
      for (int phase = 0; phase < 5; phase++) begin
         wait_records_done();
         case (phase)
            0: set_tags(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            1: set_tags(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            // small codes collide often, so earlier registers win
            2: set_tags(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                        8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                        8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)));
            3: set_tags(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom));
            default: set_tags(RST_TAG_TS, RST_TAG_RS, RST_TAG_DATA, RST_TAG_SOURCE,
                              RST_TAG_ADDRESS, RST_TAG_STAMP);
         endcase
         target = chars_sent + 50;
         while (chars_sent < target) send_record_line(chance(10));
      end
   endtask

   task automatic test_backpressure();
      int target;
      wait_records_done();
      hold_rsp_cycles = HOLD_CYCLES;
      burst_mode = 1'b1;
      target = chars_sent + 70;
      while (chars_sent < target) send_record_line(1'b0);
      burst_mode = 1'b0;
      wait_records_done();
   endtask

   task automatic test_noise();
      int target;
      target = chars_sent + 120;
      while (chars_sent < target) begin
         if (chance(60)) send_record_line(1'b1);
         else send_noise_line();
      end
   endtask

   initial begin
      clear_line();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_line_edges();
      test_record_lines();
      test_tag_settings();
      test_backpressure();
      test_noise();
      wait_records_done();
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
